// ----- sv/omni_chassis_inverse_kinematics_core_macros.svh -----
// Assertion macros for the omni chassis inverse kinematics core.
// Expect clk and rst_n in the scope of the use; no other dependencies.
`ifndef OMNI_CHASSIS_INVERSE_KINEMATICS_CORE_MACROS_SVH
`define OMNI_CHASSIS_INVERSE_KINEMATICS_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define OCIK_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define OCIK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ocik_pkg.sv -----
// Types and constants for the omni chassis inverse kinematics core.
// No dependencies.
package ocik_pkg;

  localparam int unsigned VelW    = 16;
  localparam int unsigned RadW    = 16;
  localparam int unsigned MaxW    = 17;
  localparam int unsigned DirW    = 4;
  localparam int unsigned ProdW   = VelW + RadW + 1;
  localparam int unsigned WheelW  = 19;
  localparam int unsigned MagW    = 18;
  localparam int unsigned SpeedW  = 18;
  localparam int unsigned NumW    = MagW + MaxW;
  localparam int unsigned DivSteps = MaxW;
  localparam int unsigned NumStages = 4 + DivSteps + 1;
  localparam int unsigned NumWheels = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 17;

  localparam logic [CfgIdxW-1:0] CfgRotateRadius   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxWheelSpeed  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDirectionNegate = 2'd2;

  localparam logic [RadW-1:0] RotateRadiusRst   = 16'd3277;
  localparam logic [MaxW-1:0] MaxWheelSpeedRst  = 17'd4096;
  localparam logic [DirW-1:0] DirectionNegateRst = 4'd0;

  localparam int unsigned WheelRear  = 0;
  localparam int unsigned WheelRight = 1;
  localparam int unsigned WheelFront = 2;
  localparam int unsigned WheelLeft  = 3;

  typedef logic signed [WheelW-1:0] wheel_t;
  typedef logic [MagW-1:0] mag_t;

  typedef struct packed {
    logic [NumW-1:0] work;
    logic            neg;
    wheel_t          wheel;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [NumWheels-1:0] lane;
    mag_t                      divisor;
    logic                      limited;
  } div_stage_t;

endpackage

// ----- sv/omni_chassis_inverse_kinematics_core.sv -----
// Pipeline from input transfer to result: multiply, wheel sums, peak search,
// scale multiply, 17 restoring divide steps, output register.
// Throughput: one item per cycle unless out_ready stalls the output; each stage advances when empty or drained.
// Reset: synchronous active-low rst_n clears all valid bits and loads the
// configuration registers with their defaults; payload registers keep data.
// Depends on ocik_pkg and omni_chassis_inverse_kinematics_core_macros.svh.
`include "omni_chassis_inverse_kinematics_core_macros.svh"

module omni_chassis_inverse_kinematics_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ocik_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [ocik_pkg::CfgDataW-1:0]       cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ocik_pkg::VelW-1:0]    in_vel_x,
  input  logic signed [ocik_pkg::VelW-1:0]    in_vel_y,
  input  logic signed [ocik_pkg::VelW-1:0]    in_yaw_rate,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ocik_pkg::SpeedW-1:0]  out_rear_wheel,
  output logic signed [ocik_pkg::SpeedW-1:0]  out_right_wheel,
  output logic signed [ocik_pkg::SpeedW-1:0]  out_front_wheel,
  output logic signed [ocik_pkg::SpeedW-1:0]  out_left_wheel,
  output logic                                out_was_limited
);

  localparam int unsigned NS = ocik_pkg::NumStages;
  localparam int unsigned DS = ocik_pkg::DivSteps;
  localparam int unsigned NW = ocik_pkg::NumWheels;
  localparam int unsigned StS3 = 2;
  localparam int unsigned StDv = 3;
  localparam int unsigned StOut = NS - 1;

  function automatic ocik_pkg::div_lane_t div_step(input ocik_pkg::div_lane_t ln,
                                                   input ocik_pkg::mag_t dsr);
    logic [ocik_pkg::MagW:0] trial;
    logic [ocik_pkg::MagW:0] rem;
    ocik_pkg::div_lane_t     res;
    trial = ln.work[ocik_pkg::NumW-1:ocik_pkg::MaxW-1];
    res = ln;
    if (trial >= {1'b0, dsr}) begin
      rem = trial - {1'b0, dsr};
      res.work = {rem[ocik_pkg::MagW-1:0], ln.work[ocik_pkg::MaxW-2:0], 1'b1};
    end else begin
      res.work = {trial[ocik_pkg::MagW-1:0], ln.work[ocik_pkg::MaxW-2:0], 1'b0};
    end
    return res;
  endfunction

  logic [ocik_pkg::RadW-1:0] rotate_radius_r;
  logic [ocik_pkg::MaxW-1:0] max_wheel_speed_r;
  logic [ocik_pkg::DirW-1:0] direction_negate_r;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] vld_nxt;
  logic [NS-1:0] adv;

  logic signed [ocik_pkg::ProdW-1:0] s1_prod_r;
  logic signed [ocik_pkg::ProdW-1:0] s1_prod_nxt;
  logic signed [ocik_pkg::VelW-1:0]  s1_vx_r;
  logic signed [ocik_pkg::VelW-1:0]  s1_vy_r;

  ocik_pkg::wheel_t s2_wheel_r   [NW];
  ocik_pkg::wheel_t s2_wheel_nxt [NW];
  ocik_pkg::wheel_t s2_sum       [NW];
  ocik_pkg::wheel_t rim;

  ocik_pkg::wheel_t s3_wheel_r [NW];
  ocik_pkg::mag_t   s3_mag_r   [NW];
  ocik_pkg::mag_t   s3_mag_nxt [NW];
  ocik_pkg::mag_t   s3_largest_r;
  ocik_pkg::mag_t   s3_largest_nxt;
  ocik_pkg::mag_t   peak01;
  ocik_pkg::mag_t   peak23;
  ocik_pkg::wheel_t wneg [NW];
  logic             s3_limited_r;

  ocik_pkg::div_stage_t dv_r [DS+1];
  ocik_pkg::div_stage_t dv0_nxt;

  logic signed [ocik_pkg::SpeedW-1:0] out_speed_r   [NW];
  logic signed [ocik_pkg::SpeedW-1:0] out_speed_nxt [NW];
  logic                               out_limited_r;
  logic [ocik_pkg::SpeedW-1:0]        quot_ext [NW];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotate_radius_r    <= ocik_pkg::RotateRadiusRst;
      max_wheel_speed_r  <= ocik_pkg::MaxWheelSpeedRst;
      direction_negate_r <= ocik_pkg::DirectionNegateRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ocik_pkg::CfgRotateRadius: begin
          rotate_radius_r <= cfg_data[ocik_pkg::RadW-1:0];
        end
        ocik_pkg::CfgMaxWheelSpeed: begin
          max_wheel_speed_r <= cfg_data[ocik_pkg::MaxW-1:0];
        end
        ocik_pkg::CfgDirectionNegate: begin
          direction_negate_r <= cfg_data[ocik_pkg::DirW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // stage advance: empty or downstream moving
  always_comb begin
    adv[StOut] = !vld_r[StOut] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    vld_nxt[0] = in_valid;
    for (int k = 1; k < NS; k++) begin
      vld_nxt[k] = vld_r[k-1];
    end
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_nxt[k];
        end
      end
    end
  end

  assign s1_prod_nxt = $signed(in_yaw_rate) * $signed({1'b0, rotate_radius_r});

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_prod_r <= s1_prod_nxt;
      s1_vx_r   <= in_vel_x;
      s1_vy_r   <= in_vel_y;
    end
  end

  always_comb begin
    rim = s1_prod_r[ocik_pkg::ProdW-1:ocik_pkg::ProdW-ocik_pkg::WheelW];
    s2_sum[ocik_pkg::WheelRear]  = ocik_pkg::WheelW'(s1_vy_r) + rim;
    s2_sum[ocik_pkg::WheelRight] = ocik_pkg::WheelW'(s1_vx_r) - rim;
    s2_sum[ocik_pkg::WheelFront] = ocik_pkg::WheelW'(s1_vy_r) - rim;
    s2_sum[ocik_pkg::WheelLeft]  = ocik_pkg::WheelW'(s1_vx_r) + rim;
    for (int i = 0; i < NW; i++) begin
      s2_wheel_nxt[i] = direction_negate_r[i] ? -s2_sum[i] : s2_sum[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_wheel_r <= s2_wheel_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < NW; i++) begin
      wneg[i] = -s2_wheel_r[i];
      s3_mag_nxt[i] = s2_wheel_r[i][ocik_pkg::WheelW-1] ? wneg[i][ocik_pkg::MagW-1:0]
                                                         : s2_wheel_r[i][ocik_pkg::MagW-1:0];
    end
    peak01 = (s3_mag_nxt[0] > s3_mag_nxt[1]) ? s3_mag_nxt[0] : s3_mag_nxt[1];
    peak23 = (s3_mag_nxt[2] > s3_mag_nxt[3]) ? s3_mag_nxt[2] : s3_mag_nxt[3];
    s3_largest_nxt = (peak01 > peak23) ? peak01 : peak23;
  end

  always_ff @(posedge clk) begin
    if (adv[StS3]) begin
      s3_wheel_r   <= s2_wheel_r;
      s3_mag_r     <= s3_mag_nxt;
      s3_largest_r <= s3_largest_nxt;
      s3_limited_r <= s3_largest_nxt > {1'b0, max_wheel_speed_r};
    end
  end

  always_comb begin
    dv0_nxt.divisor = s3_largest_r;
    dv0_nxt.limited = s3_limited_r;
    for (int i = 0; i < NW; i++) begin
      dv0_nxt.lane[i].work  = ocik_pkg::NumW'(s3_mag_r[i]) *
                              ocik_pkg::NumW'(max_wheel_speed_r);
      dv0_nxt.lane[i].neg   = s3_wheel_r[i][ocik_pkg::WheelW-1];
      dv0_nxt.lane[i].wheel = s3_wheel_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[StDv]) begin
      dv_r[0] <= dv0_nxt;
    end
  end

  for (genvar k = 1; k <= DS; k++) begin : g_div
    ocik_pkg::div_stage_t step_nxt;
    always_comb begin
      step_nxt = dv_r[k-1];
      for (int i = 0; i < NW; i++) begin
        step_nxt.lane[i] = div_step(dv_r[k-1].lane[i], dv_r[k-1].divisor);
      end
    end
    always_ff @(posedge clk) begin
      if (adv[StDv + k]) begin
        dv_r[k] <= step_nxt;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NW; i++) begin
      quot_ext[i] = {1'b0, dv_r[DS].lane[i].work[ocik_pkg::MaxW-1:0]};
      if (dv_r[DS].limited) begin
        out_speed_nxt[i] = dv_r[DS].lane[i].neg ? -$signed(quot_ext[i])
                                                : $signed(quot_ext[i]);
      end else begin
        out_speed_nxt[i] = dv_r[DS].lane[i].wheel[ocik_pkg::SpeedW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[StOut]) begin
      out_speed_r   <= out_speed_nxt;
      out_limited_r <= dv_r[DS].limited;
    end
  end

  assign out_valid       = vld_r[StOut];
  assign out_rear_wheel  = out_speed_r[ocik_pkg::WheelRear];
  assign out_right_wheel = out_speed_r[ocik_pkg::WheelRight];
  assign out_front_wheel = out_speed_r[ocik_pkg::WheelFront];
  assign out_left_wheel  = out_speed_r[ocik_pkg::WheelLeft];
  assign out_was_limited = out_limited_r;

  `OCIK_ASSERT_IMPL(a_peak_covers, vld_r[StS3], (s3_largest_r >= s3_mag_r[0]) && (s3_largest_r >= s3_mag_r[1]) && (s3_largest_r >= s3_mag_r[2]) && (s3_largest_r >= s3_mag_r[3]), "peak below a wheel magnitude")
  `OCIK_ASSERT_IMPL(a_num_in_range, vld_r[StDv] && dv_r[0].limited, (dv_r[0].lane[0].work[ocik_pkg::NumW-1:ocik_pkg::MaxW] < dv_r[0].divisor) && (dv_r[0].lane[3].work[ocik_pkg::NumW-1:ocik_pkg::MaxW] < dv_r[0].divisor), "scaled numerator overflows quotient width")
  `OCIK_ASSERT_IMPL(a_rem_below_div, vld_r[StOut-1] && dv_r[DS].limited, (dv_r[DS].lane[0].work[ocik_pkg::NumW-1:ocik_pkg::MaxW] < dv_r[DS].divisor) && (dv_r[DS].lane[2].work[ocik_pkg::NumW-1:ocik_pkg::MaxW] < dv_r[DS].divisor), "divider remainder not below divisor")
  `OCIK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_rear_wheel) && $stable(out_was_limited), "stalled result changed")

endmodule

// ----- dv/omni_chassis_inverse_kinematics_core_test.sv -----
// Testbench for omni_chassis_inverse_kinematics_core: a directed table of commands and
// register writes, then random phases over several register settings, all checked.
// Depends on ocik_pkg and the core RTL; wheel speeds are predicted inside the bench.
`timescale 1ns / 1ps

module omni_chassis_inverse_kinematics_core_test;

  localparam logic [ocik_pkg::CfgIdxW-1:0] CfgUnmapped = 2'd3;
  localparam int unsigned SettleCycles  = 30;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned ItemsPerPhase = 190;
  localparam int unsigned PlanRows      = 30;

  typedef struct packed {
    logic signed [ocik_pkg::SpeedW-1:0] rear;
    logic signed [ocik_pkg::SpeedW-1:0] right;
    logic signed [ocik_pkg::SpeedW-1:0] front;
    logic signed [ocik_pkg::SpeedW-1:0] left;
    logic                               limited;
  } wheel_set_t;

  typedef enum logic {RowCmd, RowReg} row_kind_t;

  typedef struct packed {
    row_kind_t                        kind;
    logic [ocik_pkg::CfgIdxW-1:0]     reg_idx;
    logic [ocik_pkg::CfgDataW-1:0]    reg_val;
    logic signed [ocik_pkg::VelW-1:0] vx;
    logic signed [ocik_pkg::VelW-1:0] vy;
    logic signed [ocik_pkg::VelW-1:0] wz;
    logic                             typed;
    wheel_set_t                       want;
  } row_t;

  logic                               clk;
  logic                               rst_n = 1'b0;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [ocik_pkg::CfgIdxW-1:0]       cfg_index = '0;
  logic [ocik_pkg::CfgDataW-1:0]      cfg_data = '0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic signed [ocik_pkg::VelW-1:0]   in_vel_x = '0;
  logic signed [ocik_pkg::VelW-1:0]   in_vel_y = '0;
  logic signed [ocik_pkg::VelW-1:0]   in_yaw_rate = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [ocik_pkg::SpeedW-1:0] out_rear_wheel;
  logic signed [ocik_pkg::SpeedW-1:0] out_right_wheel;
  logic signed [ocik_pkg::SpeedW-1:0] out_front_wheel;
  logic signed [ocik_pkg::SpeedW-1:0] out_left_wheel;
  logic                               out_was_limited;

  logic [ocik_pkg::RadW-1:0] radius_reg = ocik_pkg::RotateRadiusRst;
  logic [ocik_pkg::MaxW-1:0] limit_reg  = ocik_pkg::MaxWheelSpeedRst;
  logic [ocik_pkg::DirW-1:0] negate_reg = ocik_pkg::DirectionNegateRst;

  wheel_set_t  pending_wheels [$];
  wheel_set_t  seen_wheels;
  wheel_set_t  due_wheels;
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned ready_mode = 0;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;

  row_t plan [PlanRows] = '{
    '{RowCmd, '0, '0, 0, 0, 0, 1'b1, '{0, 0, 0, 0, 1'b0}},
    '{RowCmd, '0, '0, 100, 200, 0, 1'b1, '{200, 100, 200, 100, 1'b0}},
    '{RowCmd, '0, '0, 32767, 0, 0, 1'b1, '{0, 4096, 0, 4096, 1'b1}},
    '{RowCmd, '0, '0, -32768, 0, 0, 1'b1, '{0, -4096, 0, -4096, 1'b1}},
    '{RowCmd, '0, '0, 0, 0, -1, 1'b1, '{-1, 1, 1, -1, 1'b0}},
    '{RowCmd, '0, '0, 0, 0, 1, 1'b1, '{0, 0, 0, 0, 1'b0}},
    '{RowCmd, '0, '0, 0, 0, -32768, 1'b1, '{-4096, 4096, 4096, -4096, 1'b1}},
    '{RowCmd, '0, '0, 0, 32767, 32767, 1'b0, '0},
    '{RowCmd, '0, '0, -32768, -32768, -32768, 1'b0, '0},
    '{RowCmd, '0, '0, 4096, -4096, 0, 1'b1, '{-4096, 4096, -4096, 4096, 1'b0}},
    '{RowCmd, '0, '0, 4097, 0, 0, 1'b1, '{0, 4096, 0, 4096, 1'b1}},
    '{RowReg, ocik_pkg::CfgDirectionNegate, 17'hF, 0, 0, 0, 1'b0, '0},
    '{RowCmd, '0, '0, 100, 200, 0, 1'b1, '{-200, -100, -200, -100, 1'b0}},
    '{RowCmd, '0, '0, 1234, -567, 890, 1'b0, '0},
    '{RowReg, ocik_pkg::CfgMaxWheelSpeed, 17'd0, 0, 0, 0, 1'b0, '0},
    '{RowCmd, '0, '0, 0, 0, 0, 1'b1, '{0, 0, 0, 0, 1'b0}},
    '{RowCmd, '0, '0, 1, 0, 0, 1'b1, '{0, 0, 0, 0, 1'b1}},
    '{RowCmd, '0, '0, -32768, 32767, -32768, 1'b1, '{0, 0, 0, 0, 1'b1}},
    '{RowReg, ocik_pkg::CfgMaxWheelSpeed, 17'd131071, 0, 0, 0, 1'b0, '0},
    '{RowReg, ocik_pkg::CfgRotateRadius, 17'd65535, 0, 0, 0, 1'b0, '0},
    '{RowReg, ocik_pkg::CfgDirectionNegate, 17'h0, 0, 0, 0, 1'b0, '0},
    '{RowCmd, '0, '0, 32767, 32767, 32767, 1'b0, '0},
    '{RowCmd, '0, '0, -32768, -32768, -32768, 1'b0, '0},
    '{RowCmd, '0, '0, 0, 0, -32768, 1'b1, '{-131070, 131070, 131070, -131070, 1'b0}},
    '{RowReg, CfgUnmapped, 17'h1FFFF, 0, 0, 0, 1'b0, '0},
    '{RowCmd, '0, '0, 0, 0, -32768, 1'b1, '{-131070, 131070, 131070, -131070, 1'b0}},
    '{RowReg, ocik_pkg::CfgRotateRadius, 17'h10000, 0, 0, 0, 1'b0, '0},
    '{RowCmd, '0, '0, 0, 0, 12345, 1'b1, '{0, 0, 0, 0, 1'b0}},
    '{RowReg, ocik_pkg::CfgDirectionNegate, 17'h1A, 0, 0, 0, 1'b0, '0},
    '{RowCmd, '0, '0, 10, 20, 0, 1'b1, '{20, -10, 20, -10, 1'b0}}
  };

  omni_chassis_inverse_kinematics_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_vel_x       (in_vel_x),
    .in_vel_y       (in_vel_y),
    .in_yaw_rate    (in_yaw_rate),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_rear_wheel (out_rear_wheel),
    .out_right_wheel(out_right_wheel),
    .out_front_wheel(out_front_wheel),
    .out_left_wheel (out_left_wheel),
    .out_was_limited(out_was_limited)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic wheel_set_t solve_wheels(input logic signed [ocik_pkg::VelW-1:0] vx,
                                              input logic signed [ocik_pkg::VelW-1:0] vy,
                                              input logic signed [ocik_pkg::VelW-1:0] wz);
    longint     rim;
    longint     peak;
    longint     mag;
    longint     w [ocik_pkg::NumWheels];
    wheel_set_t res;
    rim = (longint'(wz) * longint'(radius_reg)) >>> 14;
    w[ocik_pkg::WheelRear]  = longint'(vy) + rim;
    w[ocik_pkg::WheelRight] = longint'(vx) - rim;
    w[ocik_pkg::WheelFront] = longint'(vy) - rim;
    w[ocik_pkg::WheelLeft]  = longint'(vx) + rim;
    peak = 0;
    for (int i = 0; i < ocik_pkg::NumWheels; i++) begin
      if (negate_reg[i]) w[i] = -w[i];
      mag = (w[i] < 0) ? -w[i] : w[i];
      if (mag > peak) peak = mag;
    end
    res.limited = (peak > longint'(limit_reg));
    if (res.limited) begin
      for (int i = 0; i < ocik_pkg::NumWheels; i++) begin
        w[i] = (w[i] * longint'(limit_reg)) / peak;
      end
    end
    res.rear  = w[ocik_pkg::WheelRear][ocik_pkg::SpeedW-1:0];
    res.right = w[ocik_pkg::WheelRight][ocik_pkg::SpeedW-1:0];
    res.front = w[ocik_pkg::WheelFront][ocik_pkg::SpeedW-1:0];
    res.left  = w[ocik_pkg::WheelLeft][ocik_pkg::SpeedW-1:0];
    return res;
  endfunction

  function automatic logic signed [ocik_pkg::VelW-1:0] pick_vel();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1: return ocik_pkg::VelW'(int'($urandom_range(0, 2)) - 1);
      2, 3: return ocik_pkg::VelW'(int'($urandom_range(0, 4000)) - 2000);
      default: return ocik_pkg::VelW'($urandom);
    endcase
  endfunction

  function automatic int pick_gap();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 1;
      2: return $urandom_range(2, 6);
      default: return $urandom_range(7, 20);
    endcase
  endfunction

  task automatic send_cmd(input logic signed [ocik_pkg::VelW-1:0] vx,
                          input logic signed [ocik_pkg::VelW-1:0] vy,
                          input logic signed [ocik_pkg::VelW-1:0] wz,
                          input wheel_set_t want);
    in_valid    <= 1'b1;
    in_vel_x    <= vx;
    in_vel_y    <= vy;
    in_yaw_rate <= wz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_wheels.push_back(want);
  endtask

  task automatic write_reg(input logic [ocik_pkg::CfgIdxW-1:0] idx,
                           input logic [ocik_pkg::CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      ocik_pkg::CfgRotateRadius:    radius_reg = val[ocik_pkg::RadW-1:0];
      ocik_pkg::CfgMaxWheelSpeed:   limit_reg  = val[ocik_pkg::MaxW-1:0];
      ocik_pkg::CfgDirectionNegate: negate_reg = val[ocik_pkg::DirW-1:0];
      default: ;
    endcase
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_wheels.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain_results();
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic configure_phase(input int unsigned ph);
    logic [ocik_pkg::CfgDataW-1:0] rad;
    logic [ocik_pkg::CfgDataW-1:0] lim;
    logic [ocik_pkg::CfgDataW-1:0] neg;
    rad = ocik_pkg::CfgDataW'($urandom_range(0, 131071));
    lim = ocik_pkg::CfgDataW'($urandom_range(0, 131071));
    neg = ocik_pkg::CfgDataW'($urandom_range(0, 31));
    case (ph)
      0: begin
        rad = ocik_pkg::CfgDataW'(ocik_pkg::RotateRadiusRst);
        lim = ocik_pkg::CfgDataW'(ocik_pkg::MaxWheelSpeedRst);
        neg = ocik_pkg::CfgDataW'(ocik_pkg::DirectionNegateRst);
      end
      1: begin
        rad = ocik_pkg::CfgDataW'(65535);
        lim = ocik_pkg::CfgDataW'(131071);
      end
      2: begin
        rad = '0;
        neg = ocik_pkg::CfgDataW'(15);
      end
      3: lim = ocik_pkg::CfgDataW'(1);
      4: lim = ocik_pkg::CfgDataW'($urandom_range(0, 8000));
      default: ;
    endcase
    settle();
    write_reg(ocik_pkg::CfgRotateRadius, rad);
    write_reg(ocik_pkg::CfgMaxWheelSpeed, lim);
    write_reg(ocik_pkg::CfgDirectionNegate, neg);
    if ($urandom_range(0, 1)) write_reg(CfgUnmapped, ocik_pkg::CfgDataW'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // receiver: switch between always ready, random stalls and long stall runs
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(0, 2);
      mode_left  <= $urandom_range(50, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (hold_left == 0) begin
          out_ready <= ~out_ready;
          hold_left <= $urandom_range(1, 20);
        end else begin
          hold_left <= hold_left - 1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_wheels = '{out_rear_wheel, out_right_wheel, out_front_wheel, out_left_wheel,
                      out_was_limited};
      if (pending_wheels.size() == 0) begin
        $error("unexpected result transfer: rear %0d right %0d front %0d left %0d",
               seen_wheels.rear, seen_wheels.right, seen_wheels.front, seen_wheels.left);
        mismatch_cnt++;
      end else begin
        due_wheels = pending_wheels.pop_front();
        if (seen_wheels.rear !== due_wheels.rear) begin
          $error("rear_wheel: expected %0d, got %0d", due_wheels.rear, seen_wheels.rear);
          mismatch_cnt++;
        end
        if (seen_wheels.right !== due_wheels.right) begin
          $error("right_wheel: expected %0d, got %0d", due_wheels.right, seen_wheels.right);
          mismatch_cnt++;
        end
        if (seen_wheels.front !== due_wheels.front) begin
          $error("front_wheel: expected %0d, got %0d", due_wheels.front, seen_wheels.front);
          mismatch_cnt++;
        end
        if (seen_wheels.left !== due_wheels.left) begin
          $error("left_wheel: expected %0d, got %0d", due_wheels.left, seen_wheels.left);
          mismatch_cnt++;
        end
        if (seen_wheels.limited !== due_wheels.limited) begin
          $error("was_limited: expected %0b, got %0b", due_wheels.limited,
                 seen_wheels.limited);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("omni_chassis_inverse_kinematics_core_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int                               burst_left;
    logic signed [ocik_pkg::VelW-1:0] vx;
    logic signed [ocik_pkg::VelW-1:0] vy;
    logic signed [ocik_pkg::VelW-1:0] wz;
    int                               gap;
    row_t                             p;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < PlanRows; r++) begin
      p = plan[r];
      if (p.kind == RowReg) begin
        if (r == 0 || plan[r-1].kind != RowReg) settle();
        write_reg(p.reg_idx, p.reg_val);
        if (r + 1 == PlanRows || plan[r+1].kind != RowReg) cfg_valid <= 1'b0;
      end else begin
        send_cmd(p.vx, p.vy, p.wz, p.typed ? p.want : solve_wheels(p.vx, p.vy, p.wz));
      end
    end

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      configure_phase(ph);
      for (int unsigned n = 0; n < ItemsPerPhase; n++) begin
        vx = pick_vel();
        vy = pick_vel();
        wz = pick_vel();
        send_cmd(vx, vy, wz, solve_wheels(vx, vy, wz));
        // hold the sender until the pipeline is empty once
        if (ph == 2 && n == ItemsPerPhase / 2) begin
          drain_results();
        end else if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap = pick_gap();
          if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end else begin
          burst_left--;
        end
      end
    end

    settle();
    if (mismatch_cnt == 0 && pending_wheels.size() == 0) begin
      $display("omni_chassis_inverse_kinematics_core_test: done, clean");
    end else begin
      $display("omni_chassis_inverse_kinematics_core_test: done, errors");
    end
    $finish;
  end

endmodule
